// ===== sv/po2zr_pkg.sv =====
// Shared package for the power-of-two zone sector remapper.
// Holds field widths, action and register codes, and the item flag struct.
// Used by every module of the block.
package po2zr_pkg;

	localparam int SECTOR_BITS_DEF = 48;
	localparam int ZONE_BITS_DEF = 32;

	localparam int SECTOR_W = 48;
	localparam int NSEC_W = 23;
	localparam int ZONE_W = 32;
	localparam int SPLIT_W = 32;
	localparam int ACTION_W = 3;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 48;

	localparam logic [ZONE_W-1:0] ZONE_SIZE_RESET = 32'd524288;

	localparam logic [CFG_IDX_W-1:0] REG_ZONE_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_BEGIN = 1'd1;

	localparam logic [ACTION_W-1:0] ACT_REMAP = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_SPLIT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_ZERO = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REJECT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DONE = 3'd4;

	typedef struct packed {
		logic cmd;
		logic is_read;
		logic is_mgmt;
		logic is_append;
		logic status_ok;
	} po2zr_flags_t;

endpackage

// ===== sv/po2zr_cfg.sv =====
// Configuration registers and the zone geometry derived from them.
// Depends on po2zr_pkg.
module po2zr_cfg import po2zr_pkg::*; #(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF,
	parameter int ZONE_BITS = ZONE_BITS_DEF,
	localparam int SH_W = $clog2(ZONE_BITS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic [ZONE_BITS-1:0]   zone,
	output logic [SH_W-1:0]        shift,
	output logic [ZONE_BITS-1:0]   diff,
	output logic [ZONE_BITS-1:0]   mask,
	output logic [SECTOR_BITS-1:0] target_begin,
	output logic                   hold
);

	logic [ZONE_BITS-1:0] zone_size_q;
	logic [SECTOR_BITS-1:0] target_begin_q;
	logic hold_q;
	logic [ZONE_BITS-1:0] zeff;
	logic [ZONE_BITS-1:0] zm1;
	logic [SH_W-1:0] sh;
	logic [ZONE_BITS:0] po2;
	logic [ZONE_BITS-1:0] zone_q;
	logic [SH_W-1:0] shift_q;
	logic [ZONE_BITS-1:0] diff_q;
	logic [ZONE_BITS-1:0] mask_q;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_size_q <= ZONE_BITS'(ZONE_SIZE_RESET);
			target_begin_q <= '0;
			hold_q <= 1'b1;
		end else begin
			hold_q <= wr;
			if (wr) begin
				case (cfg_index)
					REG_ZONE_SIZE: zone_size_q <= ZONE_BITS'(cfg_data);
					REG_TARGET_BEGIN: target_begin_q <= SECTOR_BITS'(cfg_data);
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		zeff = (zone_size_q == '0) ? ZONE_BITS'(1) : zone_size_q;
		zm1 = zeff - ZONE_BITS'(1);
		sh = '0;
		for (int i = 0; i < ZONE_BITS; i++) begin
			if (zm1[i]) begin
				sh = SH_W'(i + 1);
			end
		end
		po2 = (ZONE_BITS + 1)'(1) << sh;
	end

	// The geometry is registered from the zone size and follows it in the cycle after; hold covers that cycle.
	always_ff @(posedge clk) begin
		zone_q <= zeff;
		shift_q <= sh;
		diff_q <= ZONE_BITS'(po2 - {1'b0, zeff});
		mask_q <= ZONE_BITS'(po2 - (ZONE_BITS + 1)'(1));
	end

	assign zone = zone_q;
	assign shift = shift_q;
	assign diff = diff_q;
	assign mask = mask_q;
	assign target_begin = target_begin_q;
	assign hold = hold_q;

endmodule

// ===== sv/po2zr_div_cell.sv =====
// One cell of the divider chain: a single restoring step that settles one
// quotient bit and hands the word on. Depends on po2zr_pkg.
module po2zr_div_cell import po2zr_pkg::*; #(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF,
	parameter int ZONE_BITS = ZONE_BITS_DEF,
	parameter int BIT = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [ZONE_BITS-1:0]   zone,
	input  logic                   in_valid,
	input  po2zr_flags_t           in_flags,
	input  logic [NSEC_W-1:0]      in_nsec,
	input  logic [SECTOR_BITS-1:0] in_val,
	input  logic [SECTOR_BITS-1:0] in_zone_nr,
	input  logic [SECTOR_BITS-1:0] in_quo,
	input  logic [ZONE_BITS-1:0]   in_rem,
	output logic                   out_valid,
	output po2zr_flags_t           out_flags,
	output logic [NSEC_W-1:0]      out_nsec,
	output logic [SECTOR_BITS-1:0] out_val,
	output logic [SECTOR_BITS-1:0] out_zone_nr,
	output logic [SECTOR_BITS-1:0] out_quo,
	output logic [ZONE_BITS-1:0]   out_rem
);

	logic [ZONE_BITS:0] trial;
	logic ge;
	logic [ZONE_BITS-1:0] rem_n;
	logic [SECTOR_BITS-1:0] quo_n;
	logic valid_q;
	po2zr_flags_t flags_q;
	logic [NSEC_W-1:0] nsec_q;
	logic [SECTOR_BITS-1:0] val_q;
	logic [SECTOR_BITS-1:0] zone_nr_q;
	logic [SECTOR_BITS-1:0] quo_q;
	logic [ZONE_BITS-1:0] rem_q;

	always_comb begin
		trial = {in_rem, in_val[BIT]};
		ge = trial >= {1'b0, zone};
		rem_n = ge ? ZONE_BITS'(trial - {1'b0, zone}) : ZONE_BITS'(trial);
		quo_n = in_quo;
		quo_n[BIT] = ge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_q <= in_flags;
			nsec_q <= in_nsec;
			val_q <= in_val;
			zone_nr_q <= in_zone_nr;
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign out_valid = valid_q;
	assign out_flags = flags_q;
	assign out_nsec = nsec_q;
	assign out_val = val_q;
	assign out_zone_nr = zone_nr_q;
	assign out_quo = quo_q;
	assign out_rem = rem_q;

endmodule

// ===== sv/po2_zone_sector_remapper.sv =====
// Top level of the power-of-two zone sector remapper; uses po2zr_pkg, po2zr_cfg, po2zr_div_cell.
// The divider chain has one cell per quotient bit; the s1, s2 and output registers follow it.
// Throughput: one word per cycle while the sink takes words and no configuration hold is up.
// The whole pipeline stalls only when the output word is held by the sink.
// Reset is asynchronous and clears valid state; the input is held off after reset and in the
// cycle after each configuration write while the geometry settles.
module po2_zone_sector_remapper import po2zr_pkg::*; #(
	parameter int SECTOR_BITS = SECTOR_BITS_DEF,
	parameter int ZONE_BITS = ZONE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// sector, num_sectors, is_read, is_zone_mgmt, is_zone_append, status_ok, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// command
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_sector, split_length
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// action
	output logic [ACTION_W-1:0]   m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SH_W = $clog2(ZONE_BITS + 1);
	localparam int NCELL = SECTOR_BITS;
	localparam int HALF = (SECTOR_BITS + 1) / 2;
	localparam int HI = SECTOR_BITS - HALF;
	localparam int SUM_W = ((ZONE_BITS > NSEC_W) ? ZONE_BITS : NSEC_W) + 1;

	logic [ZONE_BITS-1:0] zone;
	logic [SH_W-1:0] shift;
	logic [ZONE_BITS-1:0] diff;
	logic [ZONE_BITS-1:0] mask;
	logic [SECTOR_BITS-1:0] tb;
	logic hold;
	logic adv;
	logic in_fire;
	po2zr_flags_t in_flags;
	logic [SECTOR_BITS-1:0] in_sector;
	logic [SECTOR_BITS-1:0] in_s;

	logic c_valid [0:NCELL];
	po2zr_flags_t c_flags [0:NCELL];
	logic [NSEC_W-1:0] c_nsec [0:NCELL];
	logic [SECTOR_BITS-1:0] c_val [0:NCELL];
	logic [SECTOR_BITS-1:0] c_zone_nr [0:NCELL];
	logic [SECTOR_BITS-1:0] c_quo [0:NCELL];
	logic [ZONE_BITS-1:0] c_rem [0:NCELL];

	logic [SECTOR_BITS-1:0] mul_q;
	logic valid_s1;
	po2zr_flags_t flags_s1;
	logic [NSEC_W-1:0] nsec_s1;
	logic [SECTOR_BITS-1:0] val_s1;
	logic [HALF+ZONE_BITS-1:0] plo_s1;
	logic [HI+ZONE_BITS-1:0] phi_s1;
	logic valid_s2;
	po2zr_flags_t flags_s2;
	logic [NSEC_W-1:0] nsec_s2;
	logic [SECTOR_BITS-1:0] val_s2;
	logic [SECTOR_BITS-1:0] prod_s2;

	logic [ZONE_BITS-1:0] off;
	logic fit;
	logic [ACTION_W-1:0] act;
	logic [SECTOR_BITS-1:0] osect;
	logic [ZONE_BITS-1:0] split;
	logic out_valid_q;
	logic [ACTION_W-1:0] action_q;
	logic [SECTOR_W-1:0] out_sector_q;
	logic [SPLIT_W-1:0] split_q;

	po2zr_cfg #(
		.SECTOR_BITS(SECTOR_BITS),
		.ZONE_BITS(ZONE_BITS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.zone(zone),
		.shift(shift),
		.diff(diff),
		.mask(mask),
		.target_begin(tb),
		.hold(hold)
	);

	assign adv = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv && !hold;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_flags.cmd = s_axis_tuser;
		in_flags.is_read = s_axis_tdata[71];
		in_flags.is_mgmt = s_axis_tdata[72];
		in_flags.is_append = s_axis_tdata[73];
		in_flags.status_ok = s_axis_tdata[74];
		in_sector = SECTOR_BITS'(s_axis_tdata[SECTOR_W-1:0]);
		in_s = in_sector - tb;
	end

	// A map word carries its base-relative sector; a completion carries the device
	// sector, which the chain divides by the zone size.
	assign c_valid[0] = in_fire;
	assign c_flags[0] = in_flags;
	assign c_nsec[0] = s_axis_tdata[SECTOR_W+NSEC_W-1:SECTOR_W];
	assign c_val[0] = s_axis_tuser ? in_sector : in_s;
	assign c_zone_nr[0] = in_s >> shift;
	assign c_quo[0] = '0;
	assign c_rem[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		po2zr_div_cell #(
			.SECTOR_BITS(SECTOR_BITS),
			.ZONE_BITS(ZONE_BITS),
			.BIT(SECTOR_BITS - 1 - i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(adv),
			.zone(zone),
			.in_valid(c_valid[i]),
			.in_flags(c_flags[i]),
			.in_nsec(c_nsec[i]),
			.in_val(c_val[i]),
			.in_zone_nr(c_zone_nr[i]),
			.in_quo(c_quo[i]),
			.in_rem(c_rem[i]),
			.out_valid(c_valid[i+1]),
			.out_flags(c_flags[i+1]),
			.out_nsec(c_nsec[i+1]),
			.out_val(c_val[i+1]),
			.out_zone_nr(c_zone_nr[i+1]),
			.out_quo(c_quo[i+1]),
			.out_rem(c_rem[i+1])
		);
	end

	assign mul_q = c_flags[NCELL].cmd ? c_quo[NCELL] : c_zone_nr[NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= c_valid[NCELL];
			valid_s2 <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= c_flags[NCELL];
			nsec_s1 <= c_nsec[NCELL];
			val_s1 <= c_val[NCELL];
			plo_s1 <= mul_q[HALF-1:0] * diff;
			phi_s1 <= mul_q[SECTOR_BITS-1:HALF] * diff;
			flags_s2 <= flags_s1;
			nsec_s2 <= nsec_s1;
			val_s2 <= val_s1;
			prod_s2 <= SECTOR_BITS'(plo_s1) + SECTOR_BITS'({phi_s1, {HALF{1'b0}}});
			action_q <= act;
			out_sector_q <= SECTOR_W'(osect);
			split_q <= SPLIT_W'(split);
		end
	end

	always_comb begin
		off = ZONE_BITS'(val_s2) & mask;
		fit = (SUM_W'(off) + SUM_W'(nsec_s2)) <= SUM_W'(zone);
		act = ACT_REMAP;
		osect = '0;
		split = '0;
		if (flags_s2.cmd) begin
			act = ACT_DONE;
			osect = (flags_s2.status_ok && flags_s2.is_append) ? val_s2 + prod_s2 + tb : val_s2;
		end else if (flags_s2.is_mgmt || nsec_s2 == '0 || fit) begin
			osect = val_s2 - prod_s2;
		end else if (flags_s2.is_read) begin
			if (off < zone) begin
				act = ACT_SPLIT;
				osect = val_s2 - prod_s2;
				split = zone - off;
			end else begin
				act = ACT_ZERO;
			end
		end else begin
			act = ACT_REJECT;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {split_q, out_sector_q};
	assign m_axis_tuser = action_q;

endmodule
